FILE: hw/rtl/direct_mapped_writeback_cache_tags_core_defines.svh
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_TAGS_CORE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_TAGS_CORE_DEFINES_SVH

// Assertion helpers, checked on the rising edge and disabled in reset.
`define DMC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define DMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dmc_pkg.sv
`default_nettype none

package dmc_pkg;

    // The line count is a power of two.
    localparam int NUM_LINES   = 128;
    localparam int OFFSET_BITS = 5;

    localparam int ADDR_W      = 32;
    localparam int INDEX_BITS  = $clog2(NUM_LINES);
    localparam int TAG_BITS    = ADDR_W - OFFSET_BITS - INDEX_BITS;
    localparam int BLOCK_BYTES = 1 << OFFSET_BITS;
    localparam int RD_BYTES    = (BLOCK_BYTES > 63) ? 63 : BLOCK_BYTES;

    localparam int OFFSET_W    = 5;
    localparam int BLOCK_W     = 27;
    localparam int INDEX_W     = 7;
    localparam int TAG_W       = 20;
    localparam int BYTES_W     = 6;
    localparam int COUNT_W     = 32;

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [TAG_BITS-1:0]   line_tag_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              command;
    } req_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [BLOCK_W-1:0]  block_number;
        logic [INDEX_W-1:0]  line_index;
        logic [TAG_W-1:0]    tag;
        logic                miss;
        logic                mem_read;
        logic [BYTES_W-1:0]  mem_read_bytes;
        logic                mem_write;
        logic                replacement;
        logic [TAG_W-1:0]    evicted_tag;
        logic [COUNT_W-1:0]  hit_total;
        logic [COUNT_W-1:0]  miss_total;
    } rsp_t;

    typedef struct packed {
        logic      valid;
        logic      dirty;
        line_tag_t tag;
    } line_t;

    typedef struct packed {
        logic      en;
        index_t    index;
        logic      dirty;
        line_tag_t tag;
    } line_wr_t;

    typedef struct packed {
        logic en;
        logic hit;
    } stat_upd_t;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dmc_tag_store.sv
`default_nettype none

module dmc_tag_store (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               rd_en,
    input  dmc_pkg::index_t   rd_index,
    output dmc_pkg::line_t    rd_line,
    input  dmc_pkg::line_wr_t wr
);
    import dmc_pkg::*;

    typedef struct packed {
        logic      dirty;
        line_tag_t tag;
    } entry_t;

    logic [NUM_LINES-1:0] valid_reg;
    logic [NUM_LINES-1:0] valid_next;
    entry_t               mem [NUM_LINES];
    entry_t               rd_data_reg;
    logic                 rd_valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.index] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.index] <= '{dirty: wr.dirty, tag: wr.tag};
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_index];
            rd_valid_reg <= valid_reg[rd_index];
        end
    end

    assign rd_line.valid = rd_valid_reg;
    assign rd_line.dirty = rd_data_reg.dirty;
    assign rd_line.tag   = rd_data_reg.tag;

endmodule

`default_nettype wire

FILE: hw/rtl/dmc_stats.sv
`default_nettype none

module dmc_stats (
    input  wire                                clk,
    input  wire                                rst_n,
    input  dmc_pkg::stat_upd_t                 upd,
    output logic [dmc_pkg::COUNT_W-1:0]        hit_total,
    output logic [dmc_pkg::COUNT_W-1:0]        miss_total
);
    import dmc_pkg::*;

    logic [COUNT_W-1:0] hit_reg;
    logic [COUNT_W-1:0] hit_next;
    logic [COUNT_W-1:0] miss_reg;
    logic [COUNT_W-1:0] miss_next;

    // The totals include the reference being counted now.
    assign hit_next   = hit_reg + COUNT_W'(upd.en && upd.hit);
    assign miss_next  = miss_reg + COUNT_W'(upd.en && !upd.hit);
    assign hit_total  = hit_next;
    assign miss_total = miss_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= '0;
            miss_reg <= '0;
        end
        else
        begin
            hit_reg  <= hit_next;
            miss_reg <= miss_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/direct_mapped_writeback_cache_tags_core.sv
// A result is strobed on done after the start transfer is taken, via the lookup state and done_reg.
// No new reference is taken while busy; busy is high for the lookup cycle in which
// the tag memory read data is checked and the updated line is written back.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset clears all valid bits and both counters at once; no clearing pass is needed.
`default_nettype none

`include "direct_mapped_writeback_cache_tags_core_defines.svh"

module direct_mapped_writeback_cache_tags_core (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           start,
    output logic          busy,
    input  dmc_pkg::req_t request,
    output logic          done,
    output dmc_pkg::rsp_t result
);
    import dmc_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    req_t               req_reg;
    logic               done_reg;
    rsp_t               result_reg;
    rsp_t               result_next;
    logic               accept;
    logic [ADDR_W-1:0]  blk_in;
    logic [ADDR_W-1:0]  blk;
    logic [ADDR_W-1:0]  tag_full;
    index_t             idx;
    line_tag_t          tag_cur;
    line_t              line;
    line_wr_t           line_wr;
    stat_upd_t          stat_upd;
    logic               hit;
    logic               repl;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] miss_total;

    assign busy   = (state_reg == ST_LOOKUP);
    assign accept = start && !busy;
    assign blk_in = request.address >> OFFSET_BITS;

    dmc_tag_store u_tag_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_index (blk_in[INDEX_BITS-1:0]),
        .rd_line  (line),
        .wr       (line_wr)
    );

    assign blk      = req_reg.address >> OFFSET_BITS;
    assign idx      = blk[INDEX_BITS-1:0];
    assign tag_full = blk >> INDEX_BITS;
    assign tag_cur  = tag_full[TAG_BITS-1:0];
    assign hit      = line.valid && (line.tag == tag_cur);
    assign repl     = !hit && line.valid;

    always_comb
    begin
        line_wr.en    = (state_reg == ST_LOOKUP);
        line_wr.index = idx;
        line_wr.tag   = tag_cur;
        if (hit)
        begin
            line_wr.dirty = line.dirty || (req_reg.command == CMD_WRITE);
        end
        else
        begin
            line_wr.dirty = (req_reg.command == CMD_WRITE);
        end
    end

    assign stat_upd.en  = (state_reg == ST_LOOKUP);
    assign stat_upd.hit = hit;

    dmc_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (stat_upd),
        .hit_total  (hit_total),
        .miss_total (miss_total)
    );

    always_comb
    begin
        result_next.byte_offset    = OFFSET_W'(req_reg.address & ADDR_W'(BLOCK_BYTES - 1));
        result_next.block_number   = BLOCK_W'(blk);
        result_next.line_index     = INDEX_W'(idx);
        result_next.tag            = TAG_W'(tag_full);
        result_next.miss           = !hit;
        result_next.mem_read       = !hit;
        result_next.mem_read_bytes = hit ? '0 : BYTES_W'(RD_BYTES);
        result_next.mem_write      = repl && line.dirty;
        result_next.replacement    = repl;
        result_next.evicted_tag    = repl ? TAG_W'(line.tag) : '0;
        result_next.hit_total      = hit_total;
        result_next.miss_total     = miss_total;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_LOOKUP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (state_reg == ST_LOOKUP)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `DMC_ASSERT_NEXT(a_accept_to_lookup, clk, rst_n, accept, state_reg == ST_LOOKUP, "accepted transfer did not start a lookup")
    `DMC_ASSERT_NEXT(a_lookup_to_done, clk, rst_n, state_reg == ST_LOOKUP, done && !busy, "lookup did not produce one result")
    `DMC_ASSERT_SAME(a_done_once, clk, rst_n, done, $past(state_reg) == ST_LOOKUP && !busy, "result strobe without a lookup")
    `DMC_ASSERT_SAME(a_hit_quiet, clk, rst_n, done && !result.miss, !result.mem_write && !result.replacement && result.evicted_tag == '0, "hit reported memory traffic")
    `DMC_ASSERT_SAME(a_wb_needs_repl, clk, rst_n, done && result.mem_write, result.replacement && result.miss, "writeback without a replaced line")

endmodule

`default_nettype wire
